// ===== hdl/cths_pkg.sv =====
// Package for the class header token scanner.
// Holds item and token types, character and token codes, and helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cths_pkg;

  localparam int POS_BITS = 16;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [3:0] {
    MODE_DEFAULT   = 4'b0001,
    MODE_CLASSNAME = 4'b0010,
    MODE_PARENT    = 4'b0100,
    MODE_RETTYPE   = 4'b1000
  } mode_t;

  typedef enum logic [4:0] {
    PEND_NONE    = 5'b00001,
    PEND_IDENT   = 5'b00010,
    PEND_CLASS   = 5'b00100,
    PEND_DASH    = 5'b01000,
    PEND_COMMENT = 5'b10000
  } pend_t;

  localparam logic [3:0] TOK_CLASS_KW   = 4'd0;
  localparam logic [3:0] TOK_CLASS_NAME = 4'd1;
  localparam logic [3:0] TOK_PARENT     = 4'd2;
  localparam logic [3:0] TOK_TYPE       = 4'd3;
  localparam logic [3:0] TOK_LPAREN     = 4'd4;
  localparam logic [3:0] TOK_RPAREN     = 4'd5;
  localparam logic [3:0] TOK_COMMA      = 4'd6;
  localparam logic [3:0] TOK_ARROW      = 4'd7;
  localparam logic [3:0] TOK_COLON      = 4'd8;
  localparam logic [3:0] TOK_COMMENT    = 4'd9;
  localparam logic [3:0] TOK_EOF        = 4'd10;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_L       = 8'h6C;
  localparam logic [7:0] CH_A       = 8'h61;
  localparam logic [7:0] CH_S       = 8'h73;

  localparam pos_t KW_LEN = pos_t'(5);

  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [3:0] token_type;
    pos_t       start_pos;
    pos_t       token_length;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  slot0;
    out_item_t  slot1;
  } push_t;

  function automatic pos_t sat_inc(input pos_t v);
    return (v != POS_MAX) ? v + pos_t'(1) : v;
  endfunction

  function automatic logic is_alpha_(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha_(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = CH_C;
      3'd1: r = CH_L;
      3'd2: r = CH_A;
      3'd3: r = CH_S;
      3'd4: r = CH_S;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cths_front.sv =====
// Front end of the class header token scanner: accepts bytes, keeps scan state,
// forms up to two tokens per item and hands them to the token queue.
// Depends on cths_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cths_front (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic fire,
  input  cths_pkg::in_item_t item,
  output cths_pkg::push_t    push
);

  cths_pkg::mode_t mode_r, mode_nxt;
  cths_pkg::pend_t kind_r, kind_nxt;
  cths_pkg::pos_t  pos_r, pos_nxt;
  cths_pkg::pos_t  pstart_r, pstart_nxt;
  cths_pkg::pos_t  plen_r, plen_nxt;

  logic            e0, e1;
  cths_pkg::out_item_t t0, t1;

  always_comb begin
    logic [7:0]      c;
    logic            consumed;
    logic [3:0]      id_type;
    cths_pkg::pos_t  p;

    c        = item.char_code;
    p        = pos_r;
    consumed = 1'b0;
    mode_nxt   = mode_r;
    kind_nxt   = kind_r;
    pos_nxt    = pos_r;
    pstart_nxt = pstart_r;
    plen_nxt   = plen_r;
    e0 = 1'b0;
    e1 = 1'b0;
    t0 = '0;
    t1 = '0;

    unique case (mode_r)
      cths_pkg::MODE_CLASSNAME: id_type = cths_pkg::TOK_CLASS_NAME;
      cths_pkg::MODE_PARENT:    id_type = cths_pkg::TOK_PARENT;
      default:                  id_type = cths_pkg::TOK_TYPE;
    endcase

    if (item.op == cths_pkg::OP_END) begin
      if (kind_r == cths_pkg::PEND_IDENT) begin
        e0 = 1'b1;
        t0 = '{id_type, pstart_r, plen_r, 1'b0};
      end else if (kind_r == cths_pkg::PEND_COMMENT) begin
        e0 = 1'b1;
        t0 = '{cths_pkg::TOK_COMMENT, pstart_r, plen_r, 1'b0};
      end else if (kind_r == cths_pkg::PEND_CLASS && plen_r >= cths_pkg::KW_LEN) begin
        e0 = 1'b1;
        t0 = '{cths_pkg::TOK_CLASS_KW, pstart_r, cths_pkg::KW_LEN, 1'b0};
      end
      e1 = 1'b1;
      t1 = '{cths_pkg::TOK_EOF, p, '0, 1'b1};
      mode_nxt   = cths_pkg::MODE_DEFAULT;
      kind_nxt   = cths_pkg::PEND_NONE;
      pos_nxt    = '0;
      pstart_nxt = '0;
      plen_nxt   = '0;
    end else begin
      unique case (kind_r)
        cths_pkg::PEND_IDENT: begin
          if (cths_pkg::is_word(c)) begin
            plen_nxt = cths_pkg::sat_inc(plen_r);
            consumed = 1'b1;
          end else begin
            e0 = 1'b1;
            t0 = '{id_type, pstart_r, plen_r, 1'b0};
            if (mode_r != cths_pkg::MODE_PARENT) mode_nxt = cths_pkg::MODE_DEFAULT;
            kind_nxt = cths_pkg::PEND_NONE;
          end
        end
        cths_pkg::PEND_CLASS: begin
          if (plen_r < cths_pkg::KW_LEN) begin
            if (c == cths_pkg::kw_char(plen_r[2:0])) begin
              plen_nxt = plen_r + cths_pkg::pos_t'(1);
              consumed = 1'b1;
            end else begin
              kind_nxt = cths_pkg::PEND_NONE;
            end
          end else begin
            if (!cths_pkg::is_word(c)) begin
              e0 = 1'b1;
              t0 = '{cths_pkg::TOK_CLASS_KW, pstart_r, cths_pkg::KW_LEN, 1'b0};
              mode_nxt = cths_pkg::MODE_CLASSNAME;
            end
            kind_nxt = cths_pkg::PEND_NONE;
          end
        end
        cths_pkg::PEND_DASH: begin
          if (c == cths_pkg::CH_GT) begin
            e0 = 1'b1;
            t0 = '{cths_pkg::TOK_ARROW, pstart_r, cths_pkg::pos_t'(2), 1'b0};
            mode_nxt = cths_pkg::MODE_RETTYPE;
            consumed = 1'b1;
          end
          kind_nxt = cths_pkg::PEND_NONE;
        end
        cths_pkg::PEND_COMMENT: begin
          if (c != cths_pkg::CH_NL) begin
            plen_nxt = cths_pkg::sat_inc(plen_r);
            consumed = 1'b1;
          end else begin
            e0 = 1'b1;
            t0 = '{cths_pkg::TOK_COMMENT, pstart_r, plen_r, 1'b0};
            kind_nxt = cths_pkg::PEND_NONE;
          end
        end
        default: kind_nxt = cths_pkg::PEND_NONE;
      endcase

      if (!consumed && !cths_pkg::is_space(c)) begin
        if (mode_nxt != cths_pkg::MODE_DEFAULT && cths_pkg::is_alpha_(c)) begin
          kind_nxt   = cths_pkg::PEND_IDENT;
          pstart_nxt = p;
          plen_nxt   = cths_pkg::pos_t'(1);
        end else if (mode_nxt == cths_pkg::MODE_PARENT && c == cths_pkg::CH_COMMA) begin
          e1 = 1'b1;
          t1 = '{cths_pkg::TOK_COMMA, p, cths_pkg::pos_t'(1), 1'b1};
        end else if (mode_nxt == cths_pkg::MODE_PARENT && c == cths_pkg::CH_RPAREN) begin
          e1 = 1'b1;
          t1 = '{cths_pkg::TOK_RPAREN, p, cths_pkg::pos_t'(1), 1'b1};
          mode_nxt = cths_pkg::MODE_DEFAULT;
        end else if (c == cths_pkg::CH_HASH) begin
          kind_nxt   = cths_pkg::PEND_COMMENT;
          pstart_nxt = p;
          plen_nxt   = cths_pkg::pos_t'(1);
        end else if (mode_nxt == cths_pkg::MODE_DEFAULT && c == cths_pkg::CH_C) begin
          kind_nxt   = cths_pkg::PEND_CLASS;
          pstart_nxt = p;
          plen_nxt   = cths_pkg::pos_t'(1);
        end else if (c == cths_pkg::CH_LPAREN) begin
          e1 = 1'b1;
          t1 = '{cths_pkg::TOK_LPAREN, p, cths_pkg::pos_t'(1), 1'b1};
          mode_nxt = cths_pkg::MODE_PARENT;
        end else if (c == cths_pkg::CH_RPAREN) begin
          e1 = 1'b1;
          t1 = '{cths_pkg::TOK_RPAREN, p, cths_pkg::pos_t'(1), 1'b1};
        end else if (c == cths_pkg::CH_DASH) begin
          kind_nxt   = cths_pkg::PEND_DASH;
          pstart_nxt = p;
          plen_nxt   = cths_pkg::pos_t'(1);
        end else if (c == cths_pkg::CH_COLON) begin
          e1 = 1'b1;
          t1 = '{cths_pkg::TOK_COLON, p, cths_pkg::pos_t'(1), 1'b1};
        end
      end
      pos_nxt = cths_pkg::sat_inc(p);
    end
  end

  // pack the tokens so the first one present sits in slot0
  always_comb begin
    push.cnt   = fire ? ({1'b0, e0} + {1'b0, e1}) : 2'd0;
    push.slot0 = e0 ? t0 : t1;
    push.slot0.last_of_run = !(e0 && e1);
    push.slot1 = t1;
    push.slot1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= cths_pkg::MODE_DEFAULT;
      kind_r   <= cths_pkg::PEND_NONE;
      pos_r    <= '0;
      pstart_r <= '0;
      plen_r   <= '0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      kind_r   <= kind_nxt;
      pos_r    <= pos_nxt;
      pstart_r <= pstart_nxt;
      plen_r   <= plen_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cths_queue.sv =====
// Token queue of the class header token scanner: takes up to two tokens per
// cycle from the front end and delivers one per cycle on the result channel while out_ready is high.
// Depends on cths_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cths_queue (
  input  wire                 logic clk,
  input  wire                 logic rst_n,
  input  cths_pkg::push_t     push,
  output logic                room,
  output logic                out_valid,
  input  wire                 logic out_ready,
  output cths_pkg::out_item_t out_item
);

  localparam int CW = $clog2(cths_pkg::QDEPTH + 1);

  cths_pkg::out_item_t        mem [cths_pkg::QDEPTH];
  logic [cths_pkg::QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [cths_pkg::QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic                       pop;
  logic [cths_pkg::QAW-1:0]   wr_ptr_p1;

  assign room      = count_r <= CW'(cths_pkg::QDEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_item  = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + cths_pkg::QAW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + cths_pkg::QAW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + cths_pkg::QAW'(pop);
    count_nxt  = count_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wr_ptr_r] <= push.slot0;
    if (push.cnt == 2'd2) mem[wr_ptr_p1] <= push.slot1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(cths_pkg::QDEPTH))
    else $error("token queue count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> room)
    else $error("token push without room");

  a_pair_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2 && !pop) |=> count_r == $past(count_r) + CW'(2))
    else $error("token pair not counted");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (!push.slot0.last_of_run && push.slot1.last_of_run))
    else $error("token pair marks wrong last token");
`endif

endmodule

`default_nettype wire

// ===== hdl/class_header_token_scanner.sv =====
// Class header token scanner, top level.
// Channels: in_valid/in_ready/in_item carry one source byte (op 0) or end of
// source (op 1) per item; out_valid/out_ready/out_item carry one token per item
// (type, start position, length, last-of-run flag).
// Throughput: one input item per cycle while the token queue has room for two
// tokens; the result side drains one token per cycle while out_ready is high, so a
// byte that ends one token and emits another yields two tokens delivered in turn.
// A token is written into the token queue when the byte that completes it is
// accepted, and shows on out_item once the tokens ahead of it have drained.
// The scanner's next state is formed combinationally from the accepted byte and the
// four-entry token queue sets the input stall: in_ready drops while more than
// two tokens wait.
// Reset (rst_n low, synchronous) returns the scanner to default mode at byte
// position zero and empties the queue. When the receiver stalls, tokens stay
// in the queue and in_ready falls once it cannot take a pair.
// Depends on cths_pkg, cths_front, cths_queue.
`timescale 1ns / 1ps
`default_nettype none

module class_header_token_scanner (
  input  wire                 logic clk,
  input  wire                 logic rst_n,
  input  wire                 logic in_valid,
  output logic                in_ready,
  input  cths_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  wire                 logic out_ready,
  output cths_pkg::out_item_t out_item
);

  cths_pkg::push_t push;
  logic            room;
  logic            fire;

  assign in_ready = room;
  assign fire     = in_valid && room;

  cths_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item),
    .push  (push)
  );

  cths_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== bench/class_header_token_scanner_checker.sv =====
// Token checker for the class header token scanner bench.
// Tracks the scanner state from accepted input items and compares every output token.
// Depends on cths_pkg.
`timescale 1ns / 1ps

module class_header_token_scanner_checker
  import cths_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        failures,
  output int        tokens_due,
  output int        tokens_checked
);

  localparam pos_t ONE = pos_t'(1);
  localparam pos_t ARROW_LEN = pos_t'(2);

  mode_t     scan_mode;
  pend_t     held_kind;
  pos_t      next_pos;
  pos_t      held_start;
  pos_t      held_len;
  out_item_t token_q[$];
  out_item_t run_tokens[$];

  function automatic logic letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic word(input logic [7:0] c);
    return letter(c) || (c >= "0" && c <= "9");
  endfunction

  function automatic logic blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic pos_t bump(input pos_t v);
    return (v == POS_MAX) ? v : v + ONE;
  endfunction

  function automatic logic [7:0] kw_byte(input logic [2:0] idx);
    case (idx)
      3'd0:    return CH_C;
      3'd1:    return CH_L;
      3'd2:    return CH_A;
      3'd3:    return CH_S;
      3'd4:    return CH_S;
      default: return 8'h00;
    endcase
  endfunction

  task automatic put(input logic [3:0] kind, input pos_t start, input pos_t len);
    out_item_t t;
    t.token_type   = kind;
    t.start_pos    = start;
    t.token_length = len;
    t.last_of_run  = 1'b0;
    run_tokens.insert(run_tokens.size(), t);
  endtask

  task automatic hold(input pend_t kind, input pos_t start);
    held_kind  = kind;
    held_start = start;
    held_len   = ONE;
  endtask

  task automatic drop_held();
    held_kind  = PEND_NONE;
    held_start = '0;
    held_len   = '0;
  endtask

  task automatic put_name();
    case (scan_mode)
      MODE_CLASSNAME: put(TOK_CLASS_NAME, held_start, held_len);
      MODE_PARENT:    put(TOK_PARENT, held_start, held_len);
      default:        put(TOK_TYPE, held_start, held_len);
    endcase
    if (scan_mode != MODE_PARENT) scan_mode = MODE_DEFAULT;
  endtask

  task automatic scan_new(input logic [7:0] c, input pos_t p);
    if (scan_mode != MODE_DEFAULT && letter(c)) begin
      hold(PEND_IDENT, p);
    end else if (scan_mode == MODE_PARENT && c == CH_COMMA) begin
      put(TOK_COMMA, p, ONE);
    end else if (scan_mode == MODE_PARENT && c == CH_RPAREN) begin
      put(TOK_RPAREN, p, ONE);
      scan_mode = MODE_DEFAULT;
    end else if (c == CH_HASH) begin
      hold(PEND_COMMENT, p);
    end else if (scan_mode == MODE_DEFAULT && c == CH_C) begin
      hold(PEND_CLASS, p);
    end else if (c == CH_LPAREN) begin
      put(TOK_LPAREN, p, ONE);
      scan_mode = MODE_PARENT;
    end else if (c == CH_RPAREN) begin
      put(TOK_RPAREN, p, ONE);
    end else if (c == CH_DASH) begin
      hold(PEND_DASH, p);
    end else if (c == CH_COLON) begin
      put(TOK_COLON, p, ONE);
    end
  endtask

  task automatic predict(input in_item_t it);
    logic [7:0] c;
    logic       rescan;
    pos_t       p;
    c = it.char_code;
    p = next_pos;
    rescan = 1'b1;
    run_tokens.delete();
    if (it.op == OP_END) begin
      case (held_kind)
        PEND_IDENT:   put_name();
        PEND_COMMENT: put(TOK_COMMENT, held_start, held_len);
        PEND_CLASS: begin
          if (held_len >= KW_LEN) put(TOK_CLASS_KW, held_start, KW_LEN);
        end
        default: ;
      endcase
      put(TOK_EOF, p, '0);
      scan_mode = MODE_DEFAULT;
      next_pos = '0;
      drop_held();
    end else begin
      case (held_kind)
        PEND_IDENT: begin
          if (word(c)) begin
            held_len = bump(held_len);
            rescan = 1'b0;
          end else begin
            put_name();
            drop_held();
          end
        end
        PEND_CLASS: begin
          if (held_len < KW_LEN) begin
            if (c == kw_byte(held_len[2:0])) begin
              held_len = held_len + ONE;
              rescan = 1'b0;
            end else begin
              drop_held();
            end
          end else begin
            if (!word(c)) begin
              put(TOK_CLASS_KW, held_start, KW_LEN);
              scan_mode = MODE_CLASSNAME;
            end
            drop_held();
          end
        end
        PEND_DASH: begin
          if (c == CH_GT) begin
            put(TOK_ARROW, held_start, ARROW_LEN);
            scan_mode = MODE_RETTYPE;
            rescan = 1'b0;
          end
          drop_held();
        end
        PEND_COMMENT: begin
          if (c != CH_NL) begin
            held_len = bump(held_len);
            rescan = 1'b0;
          end else begin
            put(TOK_COMMENT, held_start, held_len);
            drop_held();
          end
        end
        default: ;
      endcase
      if (rescan && !blank(c)) scan_new(c, p);
      next_pos = bump(p);
    end
    if (run_tokens.size() > 0) run_tokens[run_tokens.size() - 1].last_of_run = 1'b1;
    foreach (run_tokens[i]) token_q.insert(token_q.size(), run_tokens[i]);
  endtask

  task automatic check_token();
    out_item_t want;
    if (token_q.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("%0t: unexpected token type %0d start %0d len %0d last %0b", $realtime,
                 out_item.token_type, out_item.start_pos, out_item.token_length,
                 out_item.last_of_run);
    end else begin
      want = token_q.pop_front();
      tokens_checked++;
      if (out_item.token_type !== want.token_type || out_item.start_pos !== want.start_pos ||
          out_item.token_length !== want.token_length ||
          out_item.last_of_run !== want.last_of_run) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch, want type %0d start %0d len %0d last %0b, got %0d %0d %0d %0b",
                   $realtime, want.token_type, want.start_pos, want.token_length,
                   want.last_of_run, out_item.token_type, out_item.start_pos,
                   out_item.token_length, out_item.last_of_run);
      end
    end
  endtask

  initial begin
    failures = 0;
    tokens_due = 0;
    tokens_checked = 0;
    scan_mode = MODE_DEFAULT;
    next_pos = '0;
    drop_held();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      scan_mode = MODE_DEFAULT;
      next_pos = '0;
      drop_held();
      token_q.delete();
    end else begin
      if (out_valid && out_ready) check_token();
      if (in_valid && in_ready) predict(in_item);
    end
    tokens_due = token_q.size();
  end

endmodule

// ===== bench/class_header_token_scanner_tb.sv =====
// Top of the class header token scanner bench: clock, reset, byte stimulus and verdict.
// Sends directed and random class headers and noisy sources.
// Depends on cths_pkg, class_header_token_scanner, class_header_token_scanner_checker.
`timescale 1ns / 1ps

module class_header_token_scanner_tb;
  import cths_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1600;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  int         failures;
  int         tokens_due;
  int         tokens_checked;
  int         items_sent;
  int         sources_sent;
  int         burst_left;
  logic       gaps_on;
  logic [7:0] src_text[$];

  class_header_token_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  class_header_token_scanner_checker token_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item),
    .failures       (failures),
    .tokens_due     (tokens_due),
    .tokens_checked (tokens_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: ready pattern switches among four randomly chosen styles
  initial begin : token_sink
    int style;
    int style_left;
    out_ready = 1'b0;
    style = 0;
    style_left = 0;
    forever begin
      @(negedge clk);
      if (style_left == 0) begin
        style = $urandom_range(0, 3);
        style_left = $urandom_range(20, 200);
      end
      style_left--;
      case (style)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 1);
        2:       out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_item(input logic op_bit, input logic [7:0] code);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= '{op: op_bit, char_code: code};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_CHAR, s[i]);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tokens_due != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] alpha_byte();
    case ($urandom_range(0, 4))
      0, 1:    return 8'("a" + $urandom_range(0, 25));
      2:       return 8'("A" + $urandom_range(0, 25));
      default: return 8'h5F;
    endcase
  endfunction

  function automatic logic [7:0] word_byte();
    if ($urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
    return alpha_byte();
  endfunction

  function automatic logic [7:0] non_nl_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CH_NL) ? CH_SPACE : b;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    src_text.insert(src_text.size(), b);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_space(input int most);
    int n;
    n = $urandom_range(0, most);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0:       add_byte(8'h09);
        1:       add_byte(CH_NL);
        2:       add_byte(8'h0B);
        3:       add_byte(8'h0C);
        4:       add_byte(8'h0D);
        default: add_byte(CH_SPACE);
      endcase
    end
  endfunction

  function automatic void add_name();
    int len;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
    add_byte(alpha_byte());
    repeat (len - 1) add_byte(word_byte());
  endfunction

  function automatic void add_comment();
    int n;
    n = $urandom_range(0, 8);
    add_byte(CH_HASH);
    repeat (n) add_byte(non_nl_byte());
    if ($urandom_range(0, 3) != 0) add_byte(CH_NL);
  endfunction

  function automatic void add_header();
    int parents;
    add_space(2);
    if ($urandom_range(0, 4) == 0) add_comment();
    add_text("class");
    if ($urandom_range(0, 5) != 0) add_space(2);
    add_name();
    add_space(1);
    if ($urandom_range(0, 3) != 0) begin
      add_byte(CH_LPAREN);
      parents = $urandom_range(0, 3);
      for (int i = 0; i < parents; i++) begin
        if (i > 0) begin
          add_space(1);
          add_byte(CH_COMMA);
        end
        add_space(1);
        add_name();
      end
      add_space(1);
      add_byte(CH_RPAREN);
    end
    if ($urandom_range(0, 1) == 0) begin
      add_space(1);
      add_text("->");
      add_space(1);
      add_name();
    end
    if ($urandom_range(0, 5) != 0) add_byte(CH_COLON);
    if ($urandom_range(0, 3) == 0) add_comment();
  endfunction

  function automatic void add_noise();
    string picks;
    int    n;
    picks = "class->#(),:_x9 \nc-";
    n = $urandom_range(1, 20);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0:       add_text("clas ");
        1:       add_text("classy");
        2:       add_text("-x");
        3, 4:    add_byte(picks[$urandom_range(0, picks.len() - 1)]);
        default: add_byte(8'($urandom_range(0, 255)));
      endcase
    end
    if ($urandom_range(0, 3) == 0) add_text("class");
  endfunction

  task automatic send_source();
    src_text.delete();
    if ($urandom_range(0, 4) != 0) begin
      repeat ($urandom_range(1, 2)) add_header();
    end else begin
      add_noise();
    end
    foreach (src_text[i]) send_item(OP_CHAR, src_text[i]);
    send_item(OP_END, 8'($urandom_range(0, 255)));
    sources_sent++;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    items_sent = 0;
    sources_sent = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: keyword into open paren, parents, arrow, colon, comment, broken partials
    send_text("class(B,_9)->T:#");
    send_item(OP_CHAR, 8'hFF);
    send_item(OP_CHAR, CH_NL);
    send_text("cla-)");
    send_item(OP_END, 8'hFF);
    send_text("class");
    send_item(OP_END, 8'h00);
    sources_sent += 2;
    wait_drained();

    while (items_sent < RANDOM_ITEMS) begin
      send_source();
      if (sources_sent % 10 == 0) wait_drained();
      if ($urandom_range(0, 7) == 0) gaps_on = !gaps_on;
    end

    wait_drained();
    repeat (20) @(negedge clk);
    $display("Ran %0d sources, %0d input items, %0d tokens checked;", sources_sent,
             items_sent, tokens_checked);
    $display("random gaps and stalls, well-formed and broken headers, noisy sources.");
    if (failures == 0 && tokens_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
